>>> rtl/ngrfc_pkg.sv
// Shared constants and types for the NMEA GGA/RMC field capture unit.
package ngrfc_pkg;

  // Characters that steer the sentence parser
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChC      = 8'h43;
  localparam logic [7:0] ChLf     = 8'h0A;

  // Character positions of the sentence type letters
  localparam logic [7:0] PosGga = 8'd5;
  localparam logic [7:0] PosRmc = 8'd6;

  // Field mask after reset: fields 2, 3, 4, 5, 7 and 9
  localparam logic [15:0] MaskReset = 16'd700;
  localparam int unsigned MaskBits  = 16;

  // One result transaction
  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_addr;
    logic [7:0] store_data;
    logic       gga_ready;
    logic       rmc_ready;
    logic       sentence_end;
  } result_t;

endpackage

>>> rtl/ngrfc_core.sv
// Sentence position tracking, capture flags and buffer write decode.
module ngrfc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [15:0]         mask_i,
  output ngrfc_pkg::result_t  result_o
);

  logic [7:0] char_q, char_d;
  logic [7:0] comma_q, comma_d;
  logic [7:0] widx_q, widx_d;
  logic       cap_q, cap_d;
  logic       gga_q, gga_d;
  logic       rmc_q, rmc_d;
  logic       gga_flag_q, gga_flag_d;
  logic       rmc_flag_q, rmc_flag_d;
  logic [7:0] char_inc;
  logic       field_sel;
  logic       store;
  logic       send;

  assign char_inc  = char_q + 8'd1;
  // Fields beyond the mask width are never stored
  assign field_sel = (comma_q < 8'(ngrfc_pkg::MaskBits)) && mask_i[comma_q[3:0]];

  // Decode one byte against the current sentence state
  always_comb begin
    char_d     = char_inc;
    comma_d    = comma_q;
    widx_d     = widx_q;
    cap_d      = cap_q;
    gga_d      = gga_q;
    rmc_d      = rmc_q;
    gga_flag_d = gga_flag_q;
    rmc_flag_d = rmc_flag_q;
    store      = 1'b0;
    send       = 1'b0;
    if (byte_i == ngrfc_pkg::ChComma) begin
      comma_d = comma_q + 8'd1;
    end else if (!cap_q) begin
      if (byte_i == ngrfc_pkg::ChDollar) begin
        char_d  = 8'd1;
        comma_d = 8'd0;
        widx_d  = 8'd0;
      end else if (char_inc == ngrfc_pkg::PosGga && byte_i == ngrfc_pkg::ChG) begin
        gga_d      = 1'b1;
        cap_d      = 1'b1;
        gga_flag_d = 1'b0;
      end else if (char_inc == ngrfc_pkg::PosRmc && byte_i == ngrfc_pkg::ChC) begin
        rmc_d      = 1'b1;
        cap_d      = 1'b1;
        rmc_flag_d = 1'b0;
      end
    end else if (gga_q) begin
      if (byte_i == ngrfc_pkg::ChLf) begin
        gga_d      = 1'b0;
        cap_d      = 1'b0;
        gga_flag_d = 1'b1;
        send       = 1'b1;
      end else if (field_sel) begin
        widx_d = widx_q + 8'd1;
        store  = 1'b1;
      end
    end else if (rmc_q) begin
      if (byte_i == ngrfc_pkg::ChLf) begin
        rmc_d      = 1'b0;
        cap_d      = 1'b0;
        rmc_flag_d = 1'b1;
        send       = 1'b1;
      end
    end
  end

  // Form the result transaction from the updated state
  always_comb begin
    result_o.store_valid  = store;
    result_o.store_addr   = store ? widx_d : 8'd0;
    result_o.store_data   = store ? byte_i : 8'd0;
    result_o.gga_ready    = gga_flag_d;
    result_o.rmc_ready    = rmc_flag_d;
    result_o.sentence_end = send;
  end

  // Advance the state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q     <= 8'd0;
      comma_q    <= 8'd0;
      widx_q     <= 8'd0;
      cap_q      <= 1'b0;
      gga_q      <= 1'b0;
      rmc_q      <= 1'b0;
      gga_flag_q <= 1'b0;
      rmc_flag_q <= 1'b0;
    end else if (step_i) begin
      char_q     <= char_d;
      comma_q    <= comma_d;
      widx_q     <= widx_d;
      cap_q      <= cap_d;
      gga_q      <= gga_d;
      rmc_q      <= rmc_d;
      gga_flag_q <= gga_flag_d;
      rmc_flag_q <= rmc_flag_d;
    end
  end

endmodule

>>> rtl/nmea_gga_rmc_field_capture_unit.sv
// Top level of the NMEA GGA/RMC field capture unit.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o  | rx_byte_i
//   out     | output    | out_valid_o / out_stall_i| store_*_o, *_ready_o, sentence_end_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (gga_field_mask)
//
// One byte per cycle while the output is not stalled; a byte is registered, decoded by
// the core and its result registered in the result register, from which it is offered.
// The parser core updates its state as each byte moves on to the result register.
// Reset clears the parser state and loads the field mask with its default.
// A stalled output holds its result; the input stalls only while both
// registers are full and the output is stalled. Configuration is always ready.
module nmea_gga_rmc_field_capture_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        store_valid_o,
  output logic [7:0]  store_addr_o,
  output logic [7:0]  store_data_o,
  output logic        gga_ready_o,
  output logic        rmc_ready_o,
  output logic        sentence_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               out_valid_q;
  ngrfc_pkg::result_t out_q;
  ngrfc_pkg::result_t core_res;
  logic [15:0]        mask_q;
  logic               advance;
  logic               step;

  // Move a byte on whenever the result register can take it
  assign advance    = !(out_valid_q && out_stall_i);
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  // Hold the field mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= ngrfc_pkg::MaskReset;
    end else if (cfg_valid_i) begin
      mask_q <= cfg_data_i;
    end
  end

  // Input register: load whenever it is empty or its byte moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  ngrfc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .mask_i   (mask_q),
    .result_o (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign store_valid_o  = out_q.store_valid;
  assign store_addr_o   = out_q.store_addr;
  assign store_data_o   = out_q.store_data;
  assign gga_ready_o    = out_q.gga_ready;
  assign rmc_ready_o    = out_q.rmc_ready;
  assign sentence_end_o = out_q.sentence_end;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the NMEA GGA/RMC field capture unit.
module tb_top;
  import ngrfc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        store_valid_o;
  logic [7:0]  store_addr_o;
  logic [7:0]  store_data_o;
  logic        gga_ready_o;
  logic        rmc_ready_o;
  logic        sentence_end_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = 16'h0000;

  // Predicts the capture unit and checks its result transactions in order
  class capture_scoreboard;
    logic [15:0] field_mask;
    logic [7:0]  chr_pos;
    logic [7:0]  comma_count;
    logic [7:0]  write_addr;
    logic        capturing;
    logic        in_gga;
    logic        in_rmc;
    logic        gga_flag;
    logic        rmc_flag;
    result_t     result_q[$];
    int          errors;
    int          stores_seen;
    int          ends_seen;

    function new();
      errors = 0;
      stores_seen = 0;
      ends_seen = 0;
      field_mask = MaskReset;
      chr_pos = '0;
      comma_count = '0;
      write_addr = '0;
      capturing = 1'b0;
      in_gga = 1'b0;
      in_rmc = 1'b0;
      gga_flag = 1'b0;
      rmc_flag = 1'b0;
    endfunction

    function void load_mask(logic [15:0] m);
      field_mask = m;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    // Advance the parser state by one byte and queue the result it causes
    function void note_byte(logic [7:0] ch);
      result_t r;
      r = '0;
      chr_pos = chr_pos + 8'd1;
      if (ch == ChComma) begin
        comma_count = comma_count + 8'd1;
      end else if (!capturing) begin
        if (ch == ChDollar) begin
          chr_pos = 8'd1;
          comma_count = '0;
          write_addr = '0;
        end else if (chr_pos == PosGga && ch == ChG) begin
          in_gga = 1'b1;
          capturing = 1'b1;
          gga_flag = 1'b0;
        end else if (chr_pos == PosRmc && ch == ChC) begin
          in_rmc = 1'b1;
          capturing = 1'b1;
          rmc_flag = 1'b0;
        end
      end else if (in_gga) begin
        if (ch == ChLf) begin
          in_gga = 1'b0;
          capturing = 1'b0;
          gga_flag = 1'b1;
          r.sentence_end = 1'b1;
        end else if (comma_count < MaskBits && field_mask[comma_count[3:0]]) begin
          write_addr = write_addr + 8'd1;
          r.store_valid = 1'b1;
          r.store_addr = write_addr;
          r.store_data = ch;
        end
      end else if (in_rmc) begin
        if (ch == ChLf) begin
          in_rmc = 1'b0;
          capturing = 1'b0;
          rmc_flag = 1'b1;
          r.sentence_end = 1'b1;
        end
      end
      r.gga_ready = gga_flag;
      r.rmc_ready = rmc_flag;
      result_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (result_q.size() == 0) begin
        $error("result transaction with nothing predicted");
        errors++;
        return;
      end
      want = result_q.pop_front();
      if (want.store_valid) stores_seen++;
      if (want.sentence_end) ends_seen++;
      compare_field("store_valid", want.store_valid, got.store_valid);
      compare_field("store_addr", want.store_addr, got.store_addr);
      compare_field("store_data", want.store_data, got.store_data);
      compare_field("gga_ready", want.gga_ready, got.gga_ready);
      compare_field("rmc_ready", want.rmc_ready, got.rmc_ready);
      compare_field("sentence_end", want.sentence_end, got.sentence_end);
    endfunction

    function void finish_check();
      if (result_q.size() != 0) begin
        $error("%0d predicted results never arrived", result_q.size());
        errors++;
      end
    endfunction
  endclass

  capture_scoreboard sb = new();
  bit calm = 1'b0;
  int bytes_sent = 0;
  int mask_writes = 0;

  nmea_gga_rmc_field_capture_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .store_valid_o  (store_valid_o),
    .store_addr_o   (store_addr_o),
    .store_data_o   (store_data_o),
    .gga_ready_o    (gga_ready_o),
    .rmc_ready_o    (rmc_ready_o),
    .sentence_end_o (sentence_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  // Watch both channels at each edge: note accepted bytes, check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result('{store_valid_o, store_addr_o, store_data_o,
                          gga_ready_o, rmc_ready_o, sentence_end_o});
      end
    end
  end

  // Stall the result channel in bursts, with occasional long free runs
  initial begin
    int run;
    int hold;
    int r;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 4);
      r = $urandom_range(0, 99);
      hold = (r < 60) ? $urandom_range(1, 2) : (r < 92) ? $urandom_range(3, 6)
                                                        : $urandom_range(10, 30);
      if (run > 0) begin
        out_stall_i <= 1'b0;
        repeat (run) @(posedge clk_i);
      end
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
    end
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Send one byte, hold it until accepted, then idle for a while
  task automatic push_byte(input logic [7:0] ch);
    int gap;
    in_valid_i <= 1'b1;
    rx_byte_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_mask(input logic [15:0] m);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.load_mask(m);
    mask_writes++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    // Let the last accepted byte be noted before looking at the queue
    @(posedge clk_i);
    while (sb.pending() > 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly printable field content, now and then any byte but a line feed
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 75) return 8'h41 + 8'($urandom_range(0, 25));
    if (r < 85) return 8'h2E;
    do c = 8'($urandom_range(0, 255)); while (c == ChLf);
    return c;
  endfunction

  task automatic send_noise(input int n, input bit allow_dollar);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (!allow_dollar && c == ChDollar);
      push_byte(c);
    end
  endtask

  // Send a sentence with random field contents, optionally cut short
  task automatic send_sentence(input bit gga, input int fields, input bit closed);
    string hdr;
    int len;
    hdr = gga ? "$GPGGA" : "$GPRMC";
    for (int i = 0; i < hdr.len(); i++) push_byte(hdr[i]);
    for (int f = 0; f < fields; f++) begin
      push_byte(ChComma);
      len = $urandom_range(0, 9);
      repeat (len) push_byte(field_char());
    end
    push_byte("*");
    push_byte(8'h30 + 8'($urandom_range(0, 9)));
    push_byte(8'h41 + 8'($urandom_range(0, 5)));
    push_byte(8'h0D);
    if (closed) push_byte(ChLf);
  endtask

  // One long sentence that wraps the write address and the char count
  task automatic send_wrap_runs();
    string hdr;
    hdr = "$GPGGA";
    for (int i = 0; i < hdr.len(); i++) push_byte(hdr[i]);
    repeat (258) push_byte(field_char());
    push_byte(ChLf);
  endtask

  task automatic run_random(input int budget);
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      calm = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_sentence($urandom_range(0, 1), ($urandom_range(0, 5) == 0) ?
                      $urandom_range(15, 20) : $urandom_range(0, 14), 1'b1);
      end else if (r < 85) begin
        send_noise($urandom_range(1, 10), 1'b1);
      end else if (r < 93) begin
        send_sentence($urandom_range(0, 1), $urandom_range(0, 6), 1'b0);
      end else begin
        push_byte(ChDollar);
        push_byte("G");
        push_byte("P");
        push_byte("G");
        push_byte("S");
        push_byte("A");
        send_noise($urandom_range(0, 6), 1'b0);
        push_byte(ChLf);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [15:0] masks[6];
    masks = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h0000, 16'h0000};
    masks[4] = 16'($urandom_range(0, 65535));
    masks[5] = 16'($urandom_range(0, 65535));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: GGA opened without a leading dollar, extremes, dollar as data
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(ChComma);
    push_byte("x");
    push_byte(ChG);
    push_byte("A");
    push_byte(ChComma);
    push_byte("7");
    push_byte(ChDollar);
    push_byte(8'hFF);
    push_byte(ChComma);
    push_byte(ChComma);
    push_byte(ChComma);
    push_byte(8'h00);
    push_byte(ChLf);
    // RMC opens and ends, then a new GGA clears the GGA ready flag
    send_sentence(1'b0, 1, 1'b1);
    send_sentence(1'b1, 0, 1'b1);

    // Random sentences under the reset mask, then under each written mask
    run_random(10);
    foreach (masks[i]) begin
      drain();
      write_mask(masks[i]);
      if (masks[i] == 16'hFFFF) send_wrap_runs();
      run_random(10);
    end
    drain();
    sb.finish_check();

    $display("Sent %0d bytes under %0d mask settings plus the reset mask.",
             bytes_sent, mask_writes);
    $display("Checked %0d buffer writes and %0d sentence ends.",
             sb.stores_seen, sb.ends_seen);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // End the run if it hangs
  initial begin
    #(12 * 600000);
    $display("Some tests failed");
    $finish;
  end

endmodule
